FILE: rtl/core/isort_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package isort_pkg;

  // Number of cells in the sorting chain.
  localparam int Depth = 64;
  localparam int DataWidth = 32;

  // One input transaction.
  typedef struct packed {
    logic signed [DataWidth-1:0] value;
    logic                        last;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic signed [DataWidth-1:0] value_res;
    logic                        last_res;
    logic                        overflow;
  } result_t;

  // What one cell shows to its neighbors.
  typedef struct packed {
    logic                        valid;
    logic                        greater;
    logic signed [DataWidth-1:0] value;
  } cell_link_t;

  // Chain-wide control, the same for every cell.
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

  // Top-level control states.
  typedef enum logic [1:0] {
    ST_FILL  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/isort_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module isort_cell
  import isort_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire cell_ctrl_t                  ctrl,
  input  wire logic signed [DataWidth-1:0] din,
  input  wire cell_link_t                  left,
  input  wire cell_link_t                  right,
  output      cell_link_t                  link
);

  logic                        valid;
  logic signed [DataWidth-1:0] value;
  logic                        greater;
  logic                        take;

  // This cell's entry moves up when it is larger than the incoming value.
  assign greater = valid && (value > din);

  // A cell loads when its entry moves up, or when it is the first empty cell.
  assign take = ctrl.insert && (greater || (!valid && left.valid));

  assign link.valid   = valid;
  assign link.greater = greater;
  assign link.value   = value;

  // Valid flag: shifts down while draining, set when a value lands here.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= right.valid;
    end else if (take) begin
      valid <= 1'b1;
    end
  end

  // Entry: take the right neighbor while draining, else the left neighbor or the new value.
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= right.value;
    end else if (take) begin
      value <= left.greater ? left.value : din;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/insertion_sorter_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Streaming insertion sorter built as a chain of Depth cells, each holding one
// entry and comparing it against the incoming value in parallel. While a run
// fills, one transaction is accepted every cycle and its value is written into
// its sorted place at the clock edge that accepts it, larger entries moving up
// by one cell. A transaction marked last ends the run: the block then stops
// accepting input and drains the run through cell 0, smallest first, one result
// per cycle that the consumer accepts. Values arriving when all cells are
// occupied are dropped and every result of that run carries the overflow flag.
// No clearing pass is needed after reset.
module insertion_sorter_core
  import isort_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output      logic    item_ready,
  input  wire item_t   item,
  output      logic    result_valid,
  input  wire logic    result_ready,
  output      result_t result
);

  state_t     state;
  state_t     state_next;
  logic       dropped;
  logic       dropped_next;
  logic       item_fire;
  logic       result_fire;
  logic       full;
  cell_ctrl_t ctrl;

  cell_link_t link       [Depth];
  cell_link_t left_link  [Depth];
  cell_link_t right_link [Depth];

  // Handshake and chain control.
  assign item_ready   = (state == ST_FILL);
  assign result_valid = (state == ST_DRAIN);
  assign item_fire    = item_valid && item_ready;
  assign result_fire  = result_valid && result_ready;
  assign full         = link[Depth-1].valid;
  assign ctrl.insert  = item_fire && !full;
  assign ctrl.shift   = result_fire;

  // Results come out of the bottom cell.
  assign result.value_res = link[0].value;
  assign result.last_res  = !link[1].valid;
  assign result.overflow  = dropped;

  // The cell chain with its boundary neighbors.
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    if (i == 0) begin : g_bottom
      assign left_link[i] = '{valid: 1'b1, greater: 1'b0, value: '0};
    end else begin : g_mid_left
      assign left_link[i] = link[i-1];
    end
    if (i == Depth - 1) begin : g_top
      assign right_link[i] = '{valid: 1'b0, greater: 1'b0, value: '0};
    end else begin : g_mid_right
      assign right_link[i] = link[i+1];
    end

    isort_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .din   (item.value),
      .left  (left_link[i]),
      .right (right_link[i]),
      .link  (link[i])
    );
  end

  // Run control: fill until the last transaction, then drain.
  always_comb begin
    state_next   = state;
    dropped_next = dropped;
    unique case (state)
      ST_FILL: begin
        if (item_fire && full) begin
          dropped_next = 1'b1;
        end
        if (item_fire && item.last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (result_fire && result.last_res) begin
          state_next   = ST_FILL;
          dropped_next = 1'b0;
        end
      end
      default: begin
        state_next   = ST_FILL;
        dropped_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_FILL;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      dropped <= dropped_next;
    end
  end

`ifndef ASSERT_OFF
  // A result is only offered from an occupied bottom cell.
  a_result_from_valid_cell: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> link[0].valid)
    else $error("result offered from an empty cell");

  // A last transaction always starts draining in the next cycle.
  a_last_starts_drain: assert property (@(posedge clk) disable iff (rst)
    (item_fire && item.last) |=> result_valid)
    else $error("run end did not start draining");

  // The final result of a run empties the chain.
  a_last_result_empties: assert property (@(posedge clk) disable iff (rst)
    (result_fire && result.last_res) |=> (!result_valid && !link[0].valid && !dropped))
    else $error("chain not empty after final result");

  // Overflow can only be pending with a full chain or during draining.
  a_dropped_when_full: assert property (@(posedge clk) disable iff (rst)
    dropped |-> (full || result_valid))
    else $error("overflow flag set without a full chain");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/insertion_sorter_core_tb.sv
`timescale 1ns / 1ps

module insertion_sorter_core_tb;
  import isort_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int MaxReports = 10;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  // Local copy of the sorted store and its bookkeeping.
  logic signed [DataWidth-1:0] store_copy [Depth];
  int   store_fill;
  logic store_dropped;

  // Sorted values still owed by the block, oldest first.
  result_t pending_sorted[$];

  int  mismatches;
  int  unexpected;
  int  items_sent;
  int  runs_sent;
  int  overflow_runs;
  int  results_checked;
  int  cycle_count;
  int  stall_left;
  bit  producer_gaps;
  bit  consumer_stalls;

  insertion_sorter_core DUT (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  always #4 clk = ~clk;

  // Gap length: mostly short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 2);
    end else if (r < 95) begin
      return $urandom_range(3, 6);
    end
    return $urandom_range(10, 40);
  endfunction

  // Random element: wide values, clustered small values that repeat, and edges.
  function automatic logic signed [DataWidth-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom;
      5, 6:          return int'($urandom_range(0, 20)) - 10;
      7:             return {1'b1, {(DataWidth-1){1'b0}}} + $urandom_range(0, 3);
      8:             return {1'b0, {(DataWidth-1){1'b1}}} - $urandom_range(0, 3);
      default:       return int'($urandom_range(0, 4)) - 2;
    endcase
  endfunction

  // Insert one accepted element into the local store and, at the end of a run,
  // queue the whole run smallest first.
  function automatic void sort_insert(input logic signed [DataWidth-1:0] v,
                                      input logic lst);
    int pos;
    result_t r;
    if (store_fill >= Depth) begin
      store_dropped = 1'b1;
    end else begin
      pos = store_fill;
      while (pos > 0 && store_copy[pos-1] > v) begin
        store_copy[pos] = store_copy[pos-1];
        pos--;
      end
      store_copy[pos] = v;
      store_fill++;
    end
    if (lst) begin
      for (int k = 0; k < store_fill; k++) begin
        r.value_res = store_copy[k];
        r.last_res  = (k == store_fill - 1);
        r.overflow  = store_dropped;
        pending_sorted.push_back(r);
      end
      runs_sent++;
      if (store_dropped) begin
        overflow_runs++;
      end
      store_fill    = 0;
      store_dropped = 1'b0;
    end
  endfunction

  // Send one element and wait for its transaction; valid stays up when no gap follows.
  task automatic send_item(input logic signed [DataWidth-1:0] v, input logic lst);
    int gap;
    item_valid <= 1'b1;
    item       <= item_t'{value: v, last: lst};
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sort_insert(v, lst);
    items_sent++;
    gap = 0;
    if (producer_gaps && $urandom_range(0, 2) == 0) begin
      gap = pick_gap();
    end
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering input and hold off until every owed result has come out.
  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_sorted.size() != 0) @(posedge clk);
  endtask

  // Result side: random stalls with long and short stretches.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      result_ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (consumer_stalls && $urandom_range(0, 3) == 0) begin
      result_ready <= 1'b0;
      stall_left   <= pick_gap() - 1;
    end else begin
      result_ready <= 1'b1;
    end
  end

  // Compare each result transaction with the oldest owed value.
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_sorted.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= MaxReports) begin
          $display("Unexpected result: value %0d last %0b overflow %0b",
                   result.value_res, result.last_res, result.overflow);
        end
      end else begin
        want = pending_sorted.pop_front();
        results_checked++;
        if (result.value_res !== want.value_res || result.last_res !== want.last_res ||
            result.overflow !== want.overflow) begin
          mismatches++;
          if (mismatches + unexpected <= MaxReports) begin
            $display({"Mismatch at result %0d: expected value %0d last %0b overflow %0b,",
                      " got value %0d last %0b overflow %0b"},
                     results_checked, want.value_res, want.last_res, want.overflow,
                     result.value_res, result.last_res, result.overflow);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_sorted.size());
      $display("insertion_sorter_core test failed");
      $finish;
    end
  end

  // Runs of a single element: both extremes of the range and zero.
  task automatic test_single_runs();
    send_item(32'sh8000_0000, 1'b1);
    send_item(32'sh7fff_ffff, 1'b1);
    send_item(32'sh0000_0000, 1'b1);
  endtask

  // One run mixing both extremes, zero, alternating bit patterns and repeats.
  task automatic test_extreme_values();
    send_item(32'sh7fff_ffff, 1'b0);
    send_item(32'sh8000_0000, 1'b0);
    send_item(32'sh0000_0000, 1'b0);
    send_item(-32'sd1, 1'b0);
    send_item(32'sd1, 1'b0);
    send_item(32'sh7fff_ffff, 1'b0);
    send_item(32'sh8000_0000, 1'b0);
    send_item(32'sh5555_5555, 1'b0);
    send_item(32'shaaaa_aaaa, 1'b0);
    send_item(32'sd7, 1'b0);
    send_item(32'sd7, 1'b0);
    send_item(-32'sd5, 1'b1);
  endtask

  // Equal values throughout a run.
  task automatic test_equal_values();
    repeat (3) send_item(-32'sd42, 1'b0);
    send_item(-32'sd42, 1'b1);
  endtask

  // Depth elements in descending order fill the store, then a last element is
  // dropped; a short run after it shows the flag clear.
  task automatic test_overflow();
    for (int i = 0; i < Depth; i++) begin
      send_item(1000 - 3 * i, 1'b0);
    end
    send_item(pick_value(), 1'b1);
    send_item(32'sd3, 1'b0);
    send_item(-32'sd3, 1'b1);
  endtask

  // Hold off input until the block has emptied, then restart with no gaps at all.
  task automatic test_drain_pause();
    for (int i = 0; i < 5; i++) begin
      send_item(pick_value(), i == 4);
    end
    wait_drained();
    producer_gaps   = 1'b0;
    consumer_stalls = 1'b0;
    for (int i = 0; i < 6; i++) begin
      send_item(pick_value(), i == 5);
    end
    producer_gaps   = 1'b1;
    consumer_stalls = 1'b1;
  endtask

  // Random runs, mostly very short.
  task automatic test_random_runs();
    int sent;
    int len;
    int r;
    sent = 0;
    while (sent < 16) begin
      r = $urandom_range(0, 19);
      if (r < 14) begin
        len = $urandom_range(1, 8);
      end else begin
        len = $urandom_range(9, 16);
      end
      producer_gaps   = ($urandom_range(0, 4) != 0);
      consumer_stalls = ($urandom_range(0, 4) != 0);
      for (int i = 0; i < len; i++) begin
        send_item(pick_value(), i == len - 1);
      end
      sent += len;
      if ($urandom_range(0, 7) == 0) begin
        wait_drained();
      end
    end
  endtask

  initial begin
    store_fill      = 0;
    store_dropped   = 1'b0;
    mismatches      = 0;
    unexpected      = 0;
    items_sent      = 0;
    runs_sent       = 0;
    overflow_runs   = 0;
    results_checked = 0;
    cycle_count     = 0;
    producer_gaps   = 1'b0;
    consumer_stalls = 1'b0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_single_runs();
    producer_gaps   = 1'b1;
    consumer_stalls = 1'b1;
    test_extreme_values();
    test_equal_values();
    test_overflow();
    test_drain_pause();
    test_random_runs();

    wait_drained();
    repeat (20) @(posedge clk);

    $display("Sent %0d elements in %0d runs, %0d of them with dropped elements.",
             items_sent, runs_sent, overflow_runs);
    $display("Checked %0d sorted results; %0d mismatches, %0d unexpected.",
             results_checked, mismatches, unexpected);
    if (mismatches == 0 && unexpected == 0 && pending_sorted.size() == 0) begin
      $display("insertion_sorter_core test passed");
    end else begin
      $display("insertion_sorter_core test failed");
    end
    $finish;
  end

endmodule
